>>> sv/luhn_pkg.sv
package luhn_pkg;

    // Width of the binary card number
    localparam int CARD_W = 63;

    // Default number of decimal digits kept
    localparam int MAX_DIGITS_DEF = 19;

    // Binary bits folded into the decimal register per cycle
    localparam int BITS_PER_STEP = 3;

    // Result field widths
    localparam int BRAND_W = 2;
    localparam int COUNT_W = 5;
    localparam int LEAD_W  = 7;
    localparam int SUM_W   = 8;

    // Brand codes
    localparam logic [BRAND_W-1:0] BRAND_NONE  = 2'd0;
    localparam logic [BRAND_W-1:0] BRAND_CLS_A = 2'd1;
    localparam logic [BRAND_W-1:0] BRAND_CLS_B = 2'd2;
    localparam logic [BRAND_W-1:0] BRAND_CLS_C = 2'd3;

    // Prefix ranges and lengths used for classification
    localparam logic [LEAD_W-1:0]  PFX_A_LO  = 7'd51;
    localparam logic [LEAD_W-1:0]  PFX_A_HI  = 7'd55;
    localparam logic [LEAD_W-1:0]  PFX_B_0   = 7'd34;
    localparam logic [LEAD_W-1:0]  PFX_B_1   = 7'd37;
    localparam logic [LEAD_W-1:0]  PFX_C_LO  = 7'd40;
    localparam logic [LEAD_W-1:0]  PFX_C_HI  = 7'd49;
    localparam logic [COUNT_W-1:0] LEN_16    = 5'd16;
    localparam logic [COUNT_W-1:0] LEN_15    = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_13    = 5'd13;

endpackage

>>> sv/luhn_card_number_check.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_card_value[62:0]
// m_        out        m_valid / m_ready  m_brand_code, m_checksum_ok, m_digit_count,
//                                         m_leading_pair, m_luhn_sum
//
// After an input item is accepted, its 63 binary bits are folded, three per cycle, into a
// decimal register; the decimal digits then feed the Luhn accumulator one digit per cycle,
// and the result register is loaded last.
// One item is in work at a time; s_ready is high only while the block is idle, so a new
// item is not accepted until the result in work has been taken.
// A result waits in the output register until m_ready; no new item is taken meanwhile.
// aresetn is synchronous and active low; it clears the control state only.
module luhn_card_number_check
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CARD_W-1:0]   s_card_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BRAND_W-1:0]  m_brand_code,
    output logic                m_checksum_ok,
    output logic [COUNT_W-1:0]  m_digit_count,
    output logic [LEAD_W-1:0]   m_leading_pair,
    output logic [SUM_W-1:0]    m_luhn_sum
);

    localparam int BCD_W      = 4 * MAX_DIGITS;
    localparam int CONV_STEPS = CARD_W / BITS_PER_STEP;
    localparam int CNT_MAX    = (CONV_STEPS > MAX_DIGITS) ? CONV_STEPS : MAX_DIGITS;
    localparam int CNT_W      = $clog2(CNT_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CARD_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_dabble;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [3:0]         mod_reg, mod_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [3:0]         hi_reg, hi_next;
    logic [3:0]         lo_reg, lo_next;
    logic [3:0]         prev_reg, prev_next;
    logic [3:0]         dig1_reg, dig1_next;
    logic               m_valid_next;

    logic [3:0]         cur_dig;
    logic [4:0]         dbl;
    logic [3:0]         add_val;
    logic [4:0]         mod_sum;
    logic [LEAD_W-1:0]  lead;
    logic               ok;
    logic [BRAND_W-1:0] brand;

    assign s_ready = (state_reg == ST_IDLE);

    // Shift-and-add-3 conversion: three binary bits enter the decimal register per cycle.
    // Digits carried beyond the top of the register are dropped.
    always_comb begin
        bcd_dabble = bcd_reg;
        for (int s = 0; s < BITS_PER_STEP; s++) begin
            for (int d = 0; d < MAX_DIGITS; d++) begin
                if (bcd_dabble[4*d +: 4] >= 4'd5) begin
                    bcd_dabble[4*d +: 4] = bcd_dabble[4*d +: 4] + 4'd3;
                end
            end
            bcd_dabble = {bcd_dabble[BCD_W-2:0], bin_reg[CARD_W-1-s]};
        end
    end

    // Luhn contribution of the digit at the bottom of the decimal register
    always_comb begin
        cur_dig = bcd_reg[3:0];
        dbl     = {cur_dig, 1'b0};
        if (cnt_reg[0]) begin
            add_val = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
        end else begin
            add_val = cur_dig;
        end
        mod_sum = {1'b0, mod_reg} + {1'b0, add_val};
    end

    // Leading pair, checksum and brand from the scanned digits
    always_comb begin
        if (count_reg >= 5'd3) begin
            lead = ({3'b000, hi_reg} << 3) + ({3'b000, hi_reg} << 1) + {3'b000, lo_reg};
        end else begin
            lead = {3'b000, dig1_reg};
        end
        ok    = (mod_reg == 4'd0);
        brand = BRAND_NONE;
        if (ok) begin
            priority if (lead >= PFX_A_LO && lead <= PFX_A_HI && count_reg == LEN_16) begin
                brand = BRAND_CLS_A;
            end else if ((lead == PFX_B_0 || lead == PFX_B_1) && count_reg == LEN_15) begin
                brand = BRAND_CLS_B;
            end else if (lead >= PFX_C_LO && lead <= PFX_C_HI &&
                         (count_reg == LEN_13 || count_reg == LEN_16)) begin
                brand = BRAND_CLS_C;
            end else begin
                brand = BRAND_NONE;
            end
        end
    end

    // Sequencer: idle, convert, scan digits, load and hold result
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        sum_next     = sum_reg;
        mod_next     = mod_reg;
        count_next   = count_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        prev_next    = prev_reg;
        dig1_next    = dig1_reg;
        m_valid_next = m_valid;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bin_next   = s_card_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = bcd_dabble;
                bin_next = bin_reg << BITS_PER_STEP;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1)) begin
                    cnt_next   = '0;
                    sum_next   = '0;
                    mod_next   = '0;
                    count_next = 5'd1;
                    hi_next    = '0;
                    lo_next    = '0;
                    prev_next  = '0;
                    dig1_next  = '0;
                    state_next = ST_SCAN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                bcd_next  = bcd_reg >> 4;
                sum_next  = sum_reg + {4'b0000, add_val};
                mod_next  = (mod_sum >= 5'd10) ? 4'(mod_sum - 5'd10) : mod_sum[3:0];
                prev_next = cur_dig;
                if (cur_dig != 4'd0) begin
                    count_next = COUNT_W'(cnt_reg) + 5'd1;
                    hi_next    = cur_dig;
                    lo_next    = prev_reg;
                end
                if (cnt_reg == CNT_W'(1)) begin
                    dig1_next = cur_dig;
                end
                if (cnt_reg == CNT_W'(MAX_DIGITS - 1)) begin
                    state_next = ST_OUT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_OUT: begin
                // While m_valid is low the result is loaded and m_valid is raised; then it waits for the receiver.
                if (!m_valid) begin
                    m_valid_next = 1'b1;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid   <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        sum_reg   <= sum_next;
        mod_reg   <= mod_next;
        count_reg <= count_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        prev_reg  <= prev_next;
        dig1_reg  <= dig1_next;
    end

    // Result register, loaded once the last digit has been scanned
    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && !m_valid) begin
            m_brand_code   <= brand;
            m_checksum_ok  <= ok;
            m_digit_count  <= count_reg;
            m_leading_pair <= lead;
            m_luhn_sum     <= sum_reg;
        end
    end

endmodule

>>> sv/luhn_checker.sv
module luhn_checker
    import luhn_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [BRAND_W-1:0]  m_brand_code,
    input logic                m_checksum_ok,
    input logic [COUNT_W-1:0]  m_digit_count
);

    // Once an item is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an item was accepted");

    // No new item is taken while a result is waiting.
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_brand_code) && $stable(m_digit_count))
        else $error("result changed while stalled");

    // A brand is given only to a passing checksum.
    a_brand_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_brand_code != BRAND_NONE |-> m_checksum_ok)
        else $error("brand reported for a failing checksum");

    // The digit count is never zero.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_digit_count != 5'd0)
        else $error("digit count of zero");

endmodule

bind luhn_card_number_check luhn_checker u_luhn_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_brand_code  (m_brand_code),
    .m_checksum_ok (m_checksum_ok),
    .m_digit_count (m_digit_count)
);
